@@ rtl/core/byte_ring_buffer_assert.svh @@
// Assertion macros for the byte ring buffer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef BYTE_RING_BUFFER_ASSERT_SVH
`define BYTE_RING_BUFFER_ASSERT_SVH

`ifndef SYNTHESIS
// check with reset masking
`define BRB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check that also holds while reset is applied
`define BRB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BRB_ASSERT(lbl, clk, rst_n, prop, msg)
`define BRB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/core/brb_pkg.sv @@
// Shared types and constants for the byte ring buffer.
// No dependencies; imported by the top level.
`default_nettype none

package brb_pkg;

    localparam int BRB_DEPTH_DEF = 1024;
    localparam int BRB_BURST_DEF = 64;

    localparam int BRB_FIELD_W = 11;
    localparam int BRB_BYTE_W  = 8;
    localparam int BRB_S_DATA_W = 24;
    localparam int BRB_M_DATA_W = 48;
    localparam int BRB_M_PAD_W  = BRB_M_DATA_W - (BRB_BYTE_W + 3 + 3 * BRB_FIELD_W);

    localparam logic [BRB_FIELD_W-1:0] BRB_CNT_MAX = '1;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } brb_cmd_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_BURST = 1'b1
    } brb_state_t;

endpackage

`default_nettype wire

@@ rtl/core/brb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/byte_ring_buffer.sv @@
// Byte ring buffer top level: command decode, pointers, fill count, burst reader.
// Depends on brb_pkg, brb_ram and byte_ring_buffer_assert.svh.
`default_nettype none

// Circular byte FIFO of DEPTH bytes held in one RAM. Each input item is one
// command (s_tuser): write a byte, read a burst, remove bytes, or clear. Write,
// remove, clear, a zero-length read and a read on an empty buffer each give
// one result item. A read burst of n bytes (n = min(length, held bytes,
// READ_BURST)) starts by issuing the first RAM read, then gives one byte per
// cycle while the output is free, each from the registered RAM read; no new
// item is taken until the last byte of the burst is loaded into the output
// register. Output stalls simply hold the burst. Every result carries the data
// and free levels after the whole command. The byte store needs no clearing
// after reset; the block is ready at once.
module byte_ring_buffer
    import brb_pkg::*;
#(
    parameter int DEPTH      = BRB_DEPTH_DEF,
    parameter int READ_BURST = BRB_BURST_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [BRB_S_DATA_W-1:0] s_tdata,  // data_byte[7:0], length[18:8]
    input  wire logic [1:0]              s_tuser,  // command[1:0]
    input  wire logic                    s_tlast,  // write_last
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic      [BRB_M_DATA_W-1:0] m_tdata,  // read_byte[7:0], byte_valid[8],
                                                   // write_accepted[9], count[20:10],
                                                   // status[21], data_level[32:22],
                                                   // free_level[43:33]
    output logic                         m_tlast   // is_last
);

    `include "byte_ring_buffer_assert.svh"

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int CW     = (FILL_W > BRB_FIELD_W) ? FILL_W : BRB_FIELD_W;
    localparam int SUM_W  = CW + 1;
    localparam int BW     = $clog2(READ_BURST + 1);

    brb_state_t state_reg, state_next;

    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [BRB_FIELD_W-1:0] chunk_reg, chunk_next;
    logic [PTR_W-1:0]       baddr_reg, baddr_next;
    logic [BW-1:0]          bcnt_reg, bcnt_next;
    logic [BW-1:0]          bidx_reg, bidx_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [BRB_BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic                   out_bval_reg, out_bval_next;
    logic                   out_acc_reg, out_acc_next;
    logic [BRB_FIELD_W-1:0] out_cnt_reg, out_cnt_next;
    logic                   out_stat_reg, out_stat_next;
    logic                   out_last_reg, out_last_next;
    logic [BRB_FIELD_W-1:0] out_dlvl_reg, out_dlvl_next;
    logic [BRB_FIELD_W-1:0] out_flvl_reg, out_flvl_next;

    brb_cmd_t               cmd;
    logic [BRB_BYTE_W-1:0]  din_byte;
    logic [BRB_FIELD_W-1:0] din_len;
    logic                   out_free;
    logic                   accept;
    logic                   out_load;
    logic                   full;
    logic [CW-1:0]          fill_cw;
    logic [CW-1:0]          len_cw;
    logic [CW-1:0]          min_lf;
    logic [CW-1:0]          burst_n;
    logic [CW-1:0]          adv_n;
    logic [SUM_W-1:0]       rp_sum;
    logic [SUM_W-1:0]       rp_wrap;
    logic [PTR_W-1:0]       rp_adv;
    logic [PTR_W-1:0]       wp_inc;
    logic [PTR_W-1:0]       rp_inc;
    logic [PTR_W-1:0]       baddr_inc;
    logic [BW-1:0]          bidx_inc;
    logic                   blast;
    logic                   start_burst;
    logic [CW-1:0]          fill_next_cw;
    logic [CW-1:0]          free_next_cw;
    logic [BRB_FIELD_W-1:0] chunk_inc;

    logic                   ram_we;
    logic                   ram_re;
    logic [PTR_W-1:0]       ram_raddr;
    logic [BRB_BYTE_W-1:0]  ram_rdata;

    brb_ram #(
        .WIDTH (BRB_BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr_ptr_reg),
        .wr_data (din_byte),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign cmd      = brb_cmd_t'(s_tuser);
    assign din_byte = s_tdata[BRB_BYTE_W-1:0];
    assign din_len  = s_tdata[BRB_BYTE_W+BRB_FIELD_W-1:BRB_BYTE_W];
    assign out_free = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign full    = (fill_reg == FILL_W'(DEPTH));
    assign fill_cw = CW'(fill_reg);
    assign len_cw  = CW'(din_len);
    assign min_lf  = (len_cw < fill_cw) ? len_cw : fill_cw;
    assign burst_n = (min_lf < CW'(READ_BURST)) ? min_lf : CW'(READ_BURST);
    assign adv_n   = (cmd == CMD_READ) ? burst_n : min_lf;

    // n never exceeds the held bytes, so one conditional subtract wraps it
    assign rp_sum  = SUM_W'(rd_ptr_reg) + SUM_W'(adv_n);
    assign rp_wrap = (rp_sum >= SUM_W'(DEPTH)) ? (rp_sum - SUM_W'(DEPTH)) : rp_sum;
    assign rp_adv  = rp_wrap[PTR_W-1:0];

    assign wp_inc    = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rp_inc    = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign baddr_inc = (baddr_reg == PTR_W'(DEPTH - 1)) ? '0 : baddr_reg + 1'b1;
    assign bidx_inc  = bidx_reg + 1'b1;
    assign blast     = (bidx_inc == bcnt_reg);
    assign chunk_inc = (chunk_reg != BRB_CNT_MAX) ? chunk_reg + 1'b1 : chunk_reg;

    assign start_burst = accept && (cmd == CMD_READ) && (din_len != '0) && (burst_n != '0);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start_burst) begin
                    state_next = ST_BURST;
                end
            end
            ST_BURST: begin
                if (out_free && blast) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state machine outputs
    always_comb begin
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = out_free;
            ST_BURST: s_tready = 1'b0;
            default:  s_tready = 1'b0;
        endcase
    end

    // command datapath
    always_comb begin
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        fill_next     = fill_reg;
        chunk_next    = chunk_reg;
        baddr_next    = baddr_reg;
        bcnt_next     = bcnt_reg;
        bidx_next     = bidx_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = baddr_reg;
        out_load      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_byte_next = out_byte_reg;
        out_bval_next = out_bval_reg;
        out_acc_next  = out_acc_reg;
        out_cnt_next  = out_cnt_reg;
        out_stat_next = out_stat_reg;
        out_last_next = out_last_reg;

        if (accept) begin
            out_byte_next = '0;
            out_bval_next = 1'b0;
            out_acc_next  = 1'b0;
            out_cnt_next  = '0;
            out_stat_next = 1'b0;
            out_last_next = 1'b1;
            case (cmd)
                CMD_WRITE: begin
                    out_load = 1'b1;
                    if (!full) begin
                        ram_we       = 1'b1;
                        wr_ptr_next  = wp_inc;
                        fill_next    = fill_reg + 1'b1;
                        out_acc_next = 1'b1;
                        out_cnt_next = chunk_inc;
                        chunk_next   = chunk_inc;
                    end else begin
                        out_cnt_next = chunk_reg;
                    end
                    if (s_tlast) begin
                        chunk_next = '0;
                    end
                end
                CMD_READ: begin
                    if (din_len == '0) begin
                        out_load      = 1'b1;
                        out_stat_next = 1'b1;
                    end else if (burst_n == '0) begin
                        out_load = 1'b1;
                    end else begin
                        rd_ptr_next = rp_adv;
                        fill_next   = fill_reg - burst_n[FILL_W-1:0];
                        ram_re      = 1'b1;
                        ram_raddr   = rd_ptr_reg;
                        baddr_next  = rp_inc;
                        bcnt_next   = burst_n[BW-1:0];
                        bidx_next   = '0;
                    end
                end
                CMD_REMOVE: begin
                    out_load     = 1'b1;
                    rd_ptr_next  = rp_adv;
                    fill_next    = fill_reg - min_lf[FILL_W-1:0];
                    out_cnt_next = min_lf[BRB_FIELD_W-1:0];
                end
                CMD_CLEAR: begin
                    out_load    = 1'b1;
                    rd_ptr_next = '0;
                    wr_ptr_next = '0;
                    fill_next   = '0;
                    chunk_next  = '0;
                end
                default: begin
                    out_load = 1'b1;
                end
            endcase
        end else if (state_reg == ST_BURST && out_free) begin
            out_load      = 1'b1;
            out_byte_next = ram_rdata;
            out_bval_next = 1'b1;
            out_acc_next  = 1'b0;
            out_cnt_next  = BRB_FIELD_W'(bidx_inc);
            out_stat_next = 1'b0;
            out_last_next = blast;
            bidx_next     = bidx_inc;
            if (!blast) begin
                ram_re     = 1'b1;
                ram_raddr  = baddr_reg;
                baddr_next = baddr_inc;
            end
        end

        if (out_load) begin
            m_tvalid_next = 1'b1;
        end
    end

    // levels after the whole command
    assign fill_next_cw = CW'(fill_next);
    assign free_next_cw = CW'(DEPTH) - fill_next_cw;

    always_comb begin
        out_dlvl_next = out_dlvl_reg;
        out_flvl_next = out_flvl_reg;
        if (out_load) begin
            out_dlvl_next = fill_next_cw[BRB_FIELD_W-1:0];
            out_flvl_next = free_next_cw[BRB_FIELD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            fill_reg     <= '0;
            chunk_reg    <= '0;
            baddr_reg    <= '0;
            bcnt_reg     <= '0;
            bidx_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            fill_reg     <= fill_next;
            chunk_reg    <= chunk_next;
            baddr_reg    <= baddr_next;
            bcnt_reg     <= bcnt_next;
            bidx_reg     <= bidx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
        out_bval_reg <= out_bval_next;
        out_acc_reg  <= out_acc_next;
        out_cnt_reg  <= out_cnt_next;
        out_stat_reg <= out_stat_next;
        out_last_reg <= out_last_next;
        out_dlvl_reg <= out_dlvl_next;
        out_flvl_reg <= out_flvl_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {BRB_M_PAD_W'(0), out_flvl_reg, out_dlvl_reg, out_stat_reg,
                       out_cnt_reg, out_acc_reg, out_bval_reg, out_byte_reg};

    `BRB_ASSERT(a_fill_bound, aclk, aresetn, fill_reg <= FILL_W'(DEPTH), "fill count above depth")
    `BRB_ASSERT(a_ptr_bound, aclk, aresetn,
        (SUM_W'(rd_ptr_reg) < SUM_W'(DEPTH)) && (SUM_W'(wr_ptr_reg) < SUM_W'(DEPTH)),
        "pointer out of range")
    `BRB_ASSERT(a_burst_idx, aclk, aresetn,
        (state_reg == ST_BURST) |-> (bidx_reg < bcnt_reg), "burst index past burst length")
    `BRB_ASSERT(a_burst_end, aclk, aresetn,
        ((state_reg == ST_BURST) && out_free && blast)
            |=> (m_tvalid && m_tlast && (state_reg == ST_IDLE)),
        "burst did not close with a last item")
    `BRB_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

`default_nettype wire
